/* hdl/lkvc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the LRU key-value cache
// Field widths, action codes, miss value and the per-cell control group.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int KEY_W  = 32;
	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
	localparam logic [DATA_W-1:0] MISS_VALUE = '1;

	// action codes
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_SET = 1'b1;

	// control broadcast to every cell
	typedef struct packed {
		logic cmp_en;  // latch the key match of the incoming item
		logic upd_en;  // apply a set: cells up to the limit take their neighbor
	} lkvc_ctrl_t;

endpackage
`default_nettype wire

/* hdl/lkvc_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_cell: one entry of the recency-ordered chain
// Holds key, value and valid mark; compares against the incoming key and,
// on a set that reaches its position, takes the entry of its younger neighbor.
// ----------------------------------------------------------------------------
module lkvc_cell
	import lkvc_pkg::*;
#(
	parameter int IDX_W = 4,
	parameter int IDX   = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lkvc_ctrl_t        ctrl,
	input  logic [IDX_W-1:0]  limit,
	input  logic [KEY_W-1:0]  cmp_key,
	input  logic [KEY_W-1:0]  prev_key,
	input  logic [DATA_W-1:0] prev_value,
	input  logic              prev_valid,
	output logic [KEY_W-1:0]  ent_key,
	output logic [DATA_W-1:0] ent_value,
	output logic              ent_valid,
	output logic              match
);

	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] value_q;
	logic              valid_q;
	logic              match_q;
	logic              shift;

	// cells at positions 0..limit move one step older
	assign shift = ctrl.upd_en && (IDX_W'(IDX) <= limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (shift) begin
				valid_q <= prev_valid;
			end
			if (ctrl.cmp_en) begin
				match_q <= valid_q && (key_q == cmp_key);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			key_q   <= prev_key;
			value_q <= prev_value;
		end
	end

	assign ent_key   = key_q;
	assign ent_value = value_q;
	assign ent_valid = valid_q;
	assign match     = match_q;

endmodule
`default_nettype wire

/* hdl/lru_key_value_cache_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit: least-recently-used key-value store
// Chain of entry cells kept in recency order, most recent at cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one item: action, key, data_in.
//   A get (action 0) yields one result item on the output channel
//   (out_valid/out_stall): hit and read_value (-1 on a miss). A set (action 1)
//   yields no result. Capacity is written through cfg_wr_en/cfg_wr_data while
//   the block is idle; 0 acts as 1, values above ENTRIES act as ENTRIES.
// Timing:
//   One item at a time. In the accept cycle every cell compares its key with
//   the incoming one; then, in the update state, the chain shifts for a set
//   or the result register loads for a get. in_stall is high during the
//   update state. A get result shows in the cycle after its update.
// Reset:
//   arst_n empties the store (all valid marks cleared, occupancy zero) and
//   sets the capacity to 16.
// Backpressure:
//   The result register holds while out_stall is high. A following set is
//   still taken; a following get waits in its update cycle until the result
//   register is free.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit
	import lkvc_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration
	input  logic                     cfg_wr_en,
	input  logic [CAP_W-1:0]         cfg_wr_data,
	// input items
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     action,
	input  logic signed [KEY_W-1:0]  key,
	input  logic signed [DATA_W-1:0] data_in,
	// result items
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     hit,
	output logic signed [DATA_W-1:0] read_value
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

	state_t            state_q;
	logic [CAP_W-1:0]  cap_q;
	logic [OCC_W-1:0]  occ_q;
	logic              out_valid_q;
	logic              hit_q;
	logic [DATA_W-1:0] value_q;

	// item held for its update cycle
	logic              act_q;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] data_q;

	logic              in_accept;
	logic              out_free;
	logic              upd_go;
	logic              is_set;
	logic              evict;
	logic [CMP_W-1:0]  cap_ext;
	logic [CMP_W-1:0]  eff_cap;
	logic [OCC_W-1:0]  occ_m1;
	logic [IDX_W-1:0]  limit;
	lkvc_ctrl_t        ctrl;

	// chain links: position 0 is the new item, position i+1 is cell i
	logic [KEY_W-1:0]  chain_key   [ENTRIES+1];
	logic [DATA_W-1:0] chain_value [ENTRIES+1];
	logic              chain_valid [ENTRIES+1];
	logic [ENTRIES-1:0] match_vec;

	logic              hit_any;
	logic [IDX_W-1:0]  hit_idx;
	logic [DATA_W-1:0] hit_value;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign is_set    = (act_q == ACT_SET);
	assign out_free  = !out_valid_q || !out_stall;
	assign upd_go    = (state_q == ST_UPDATE) && (is_set || out_free);

	assign ctrl.cmp_en = in_accept;
	assign ctrl.upd_en = upd_go && is_set;

	// effective capacity, clamped to 1..ENTRIES
	always_comb begin
		cap_ext = CMP_W'(cap_q);
		priority if (cap_ext == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end

	// a new key with the store at or over capacity drops the oldest entry
	assign evict  = CMP_W'(occ_q) >= eff_cap;
	assign occ_m1 = occ_q - OCC_W'(1);

	// last cell that moves: the matching entry on an update, otherwise the
	// oldest valid cell (evict) or the first empty one
	always_comb begin
		priority if (hit_any) begin
			limit = hit_idx;
		end else if (evict) begin
			limit = occ_m1[IDX_W-1:0];
		end else begin
			limit = occ_q[IDX_W-1:0];
		end
	end

	// keys are unique among valid cells, so at most one match bit is set
	always_comb begin
		hit_idx   = '0;
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_vec[i]) begin
				hit_idx   = hit_idx | IDX_W'(i);
				hit_value = hit_value | chain_value[i+1];
			end
		end
	end
	assign hit_any = |match_vec;

	assign chain_key[0]   = key_q;
	assign chain_value[0] = data_q;
	assign chain_valid[0] = 1'b1;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		lkvc_cell #(
			.IDX_W (IDX_W),
			.IDX   (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.limit      (limit),
			.cmp_key    (key),
			.prev_key   (chain_key[g]),
			.prev_value (chain_value[g]),
			.prev_valid (chain_valid[g]),
			.ent_key    (chain_key[g+1]),
			.ent_value  (chain_value[g+1]),
			.ent_valid  (chain_valid[g+1]),
			.match      (match_vec[g])
		);
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			act_q  <= action;
			key_q  <= key;
			data_q <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			value_q     <= '0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (upd_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// occupancy grows only on a new key that needs no eviction
			if (upd_go && is_set && !hit_any && !evict) begin
				occ_q <= occ_q + OCC_W'(1);
			end

			if (upd_go && !is_set) begin
				out_valid_q <= 1'b1;
				hit_q       <= hit_any;
				value_q     <= hit_any ? hit_value : MISS_VALUE;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = value_q;

endmodule
`default_nettype wire

/* hdl/lkvc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_checker: port-level checks for the LRU key-value cache
// Watches handshakes and results at the top-level ports.
// ----------------------------------------------------------------------------
module lkvc_checker
	import lkvc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              action,
	input logic              out_valid,
	input logic              out_stall,
	input logic              hit,
	input logic [DATA_W-1:0] read_value
);

	// one item at a time: an accepted item blocks the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken in the cycle after an accept");

	// a fresh result comes from an accepted get
	a_result_from_get: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && (action == ACT_GET), 2))
		else $error("result without a matching get");

	// a set on an empty output side leaves it empty
	a_set_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (action == ACT_SET) && !out_valid)
			|=> !out_valid ##1 !out_valid)
		else $error("set produced a result");

	// a miss always reports the miss value
	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (read_value == MISS_VALUE))
		else $error("miss with a value other than -1");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.action     (action),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.hit        (hit),
	.read_value (read_value)
);
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for lru_key_value_cache_unit
// A directed table covers empty-store misses, key and value extremes, updates
// of present keys and capacity corner cases. Random phases follow at several
// capacities and idling mixes. Every get result is checked against an
// in-bench LRU model, or against its own expectation on a typed table row.
// ----------------------------------------------------------------------------
module tb;
	import lkvc_pkg::*;

	localparam int ENTRIES        = 16;
	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no item moving
	localparam int SETTLE_CYCLES  = 4;     // a set finishes inside this after accept
	localparam int NUM_PHASES     = 8;
	localparam int PHASE_ITEMS    = 104;
	localparam int HOLD_OFF       = 250;   // long receiver stall in the pressure step

	typedef enum logic {ROW_ITEM = 1'b0, ROW_CFG = 1'b1} row_kind_t;

	// one row of the directed table; typed rows carry their own expectation
	typedef struct packed {
		row_kind_t           kind;
		logic                act;
		logic [KEY_W-1:0]    k;
		logic [DATA_W-1:0]   d;
		logic                typed;
		logic                exp_hit;
		logic [DATA_W-1:0]   exp_val;
		logic [CAP_W-1:0]    cap;
	} plan_row_t;

	typedef struct packed {
		logic [KEY_W-1:0]  k;
		logic [DATA_W-1:0] v;
	} cache_entry_t;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] v;
	} read_result_t;

	localparam int NROWS = 26;
	localparam plan_row_t PLAN [NROWS] = '{
		// empty store: every get misses
		'{ROW_ITEM, ACT_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE, 5'd0},
		'{ROW_ITEM, ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, MISS_VALUE, 5'd0},
		// key and value extremes
		'{ROW_ITEM, ACT_SET, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
		'{ROW_ITEM, ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000, 5'd0},
		'{ROW_ITEM, ACT_SET, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 5'd0},
		'{ROW_ITEM, ACT_GET, 32'h8000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'h7FFF_FFFF, 5'd0},
		// overwrite of a present key, value equal to the miss pattern
		'{ROW_ITEM, ACT_SET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 5'd0},
		'{ROW_ITEM, ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
		'{ROW_ITEM, ACT_SET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 5'd0},
		'{ROW_ITEM, ACT_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 5'd0},
		// capacity 0 acts as 1, and sits below occupancy: one eviction per insert
		'{ROW_CFG,  ACT_GET, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 5'd0},
		'{ROW_ITEM, ACT_SET, 32'h0000_0005, 32'h0000_0055, 1'b0, 1'b0, 32'h0, 5'd0},
		'{ROW_ITEM, ACT_SET, 32'h0000_0006, 32'h0000_0066, 1'b0, 1'b0, 32'h0, 5'd0},
		'{ROW_ITEM, ACT_GET, 32'h0000_0005, 32'h0, 1'b0, 1'b0, 32'h0, 5'd0},
		'{ROW_ITEM, ACT_GET, 32'h0000_0006, 32'h0, 1'b0, 1'b0, 32'h0, 5'd0},
		'{ROW_ITEM, ACT_GET, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, 32'h0, 5'd0},
		// capacity above ENTRIES acts as ENTRIES
		'{ROW_CFG,  ACT_GET, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 5'd31},
		'{ROW_ITEM, ACT_SET, 32'h0000_0007, 32'h0000_0077, 1'b0, 1'b0, 32'h0, 5'd0},
		'{ROW_ITEM, ACT_GET, 32'h0000_0006, 32'h0, 1'b0, 1'b0, 32'h0, 5'd0},
		// small capacity, inserts evict the oldest
		'{ROW_CFG,  ACT_GET, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 5'd3},
		'{ROW_ITEM, ACT_SET, 32'h0000_0008, 32'h0000_0088, 1'b0, 1'b0, 32'h0, 5'd0},
		'{ROW_ITEM, ACT_SET, 32'h0000_0009, 32'h0000_0099, 1'b0, 1'b0, 32'h0, 5'd0},
		'{ROW_ITEM, ACT_GET, 32'h0000_0006, 32'h0, 1'b0, 1'b0, 32'h0, 5'd0},
		'{ROW_ITEM, ACT_GET, 32'h0000_0007, 32'h0, 1'b0, 1'b0, 32'h0, 5'd0},
		'{ROW_ITEM, ACT_GET, 32'h0000_0009, 32'h0, 1'b0, 1'b0, 32'h0, 5'd0},
		'{ROW_CFG,  ACT_GET, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 5'd16}
	};

	// capacity per random phase: extremes plus a few in between
	localparam logic [CAP_W-1:0] PHASE_CAP [NUM_PHASES] = '{
		5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd3, 5'd8, 5'd16
	};

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     cfg_wr_en   = 1'b0;
	logic [CAP_W-1:0]         cfg_wr_data = '0;
	logic                     in_valid    = 1'b0;
	logic                     in_stall;
	logic                     action      = ACT_GET;
	logic signed [KEY_W-1:0]  key         = '0;
	logic signed [DATA_W-1:0] data_in     = '0;
	logic                     out_valid;
	logic                     out_stall   = 1'b0;
	logic                     hit;
	logic signed [DATA_W-1:0] read_value;

	// recency-ordered copy of the store, index 0 = most recent
	cache_entry_t lru_order [$];
	int unsigned  cap_eff = ENTRIES;
	read_result_t pending_reads [$];

	int errors        = 0;
	int tx_idle_pct   = 0;
	int rx_stall_pct  = 0;
	int hold_cycles   = 0;
	int quiet_cycles  = 0;

	lru_key_value_cache_unit #(.ENTRIES(ENTRIES)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.key         (key),
		.data_in     (data_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit         (hit),
		.read_value  (read_value)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int find_entry(input logic [KEY_W-1:0] k);
		foreach (lru_order[i])
			if (lru_order[i].k == k) return i;
		return -1;
	endfunction

	// one accepted item against the LRU copy; gets leave recency alone
	function automatic void lru_cache_step(input logic act, input logic [KEY_W-1:0] k,
		input logic [DATA_W-1:0] d, output logic produces, output read_result_t res);
		int pos;
		cache_entry_t e;
		pos      = find_entry(k);
		produces = (act == ACT_GET);
		res.hit  = (pos >= 0);
		res.v    = (pos >= 0) ? lru_order[pos].v : MISS_VALUE;
		if (act == ACT_SET) begin
			if (pos >= 0) begin
				lru_order.delete(pos);
			end else if (lru_order.size() + 1 > cap_eff) begin
				// only one victim even when occupancy is above capacity
				void'(lru_order.pop_back());
			end
			e.k = k;
			e.v = d;
			lru_order.push_front(e);
		end
	endfunction

	// called at a rising edge; returns at the edge that accepts the item
	task automatic send_item(input logic act, input logic [KEY_W-1:0] k,
		input logic [DATA_W-1:0] d, input logic typed, input read_result_t typed_res);
		logic produces;
		read_result_t res;
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		action   <= act;
		key      <= k;
		data_in  <= d;
		do @(posedge clk); while (in_stall);
		lru_cache_step(act, k, d, produces, res);
		if (produces) pending_reads.push_back(typed ? typed_res : res);
	endtask

	// sender pauses until every read has come back and any set has settled
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		if (v == 0) cap_eff = 1;
		else if (v > ENTRIES) cap_eff = ENTRIES;
		else cap_eff = v;
	endtask

	// result side: check accepted items, then pick the next stall
	initial begin
		read_result_t want;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_reads.size() == 0) begin
					$display("%0t: unexpected item: expected none, actual hit=%0b read_value=%h",
						$time, hit, read_value);
					errors++;
				end else begin
					want = pending_reads.pop_front();
					if (hit !== want.hit) begin
						$display("%0t: hit mismatch: expected %0b, actual %0b",
							$time, want.hit, hit);
						errors++;
					end
					if (read_value !== want.v) begin
						$display("%0t: read_value mismatch: expected %h, actual %h",
							$time, want.v, read_value);
						errors++;
					end
				end
			end
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (rx_stall_pct != 0) begin
				out_stall <= ($urandom_range(99) < rx_stall_pct);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog: cycles in which neither channel moves an item
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		read_result_t      typed_res;
		read_result_t      no_res;
		logic              act;
		logic [KEY_W-1:0]  k;
		logic [DATA_W-1:0] d;
		logic [KEY_W-1:0]  key_pool [24];
		int                pool_n;

		no_res = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		foreach (PLAN[i]) begin
			if (PLAN[i].kind == ROW_CFG) begin
				write_capacity(PLAN[i].cap);
			end else begin
				typed_res.hit = PLAN[i].exp_hit;
				typed_res.v   = PLAN[i].exp_val;
				send_item(PLAN[i].act, PLAN[i].k, PLAN[i].d, PLAN[i].typed, typed_res);
			end
		end

		// pressure: receiver holds off long while gets keep coming, so the
		// result register fills and the input side stalls
		drain_results();
		hold_cycles = HOLD_OFF;
		for (int n = 0; n < 16; n++) begin
			act = (n % 4 == 0) ? ACT_SET : ACT_GET;
			send_item(act, KEY_W'(n % 5), $urandom, 1'b0, no_res);
		end
		drain_results();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_capacity(PHASE_CAP[p]);
			case (p % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
				default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
			endcase
			// small key pool so sets and gets meet; size spans the capacity
			pool_n = $urandom_range(2, 24);
			foreach (key_pool[j]) key_pool[j] = $urandom;
			if (p == 2) key_pool[0] = 32'h8000_0000;
			if (p == 5) key_pool[0] = 32'h7FFF_FFFF;
			repeat (PHASE_ITEMS) begin
				act = $urandom_range(1) ? ACT_SET : ACT_GET;
				if ($urandom_range(9) < 8) k = key_pool[$urandom_range(pool_n - 1)];
				else k = $urandom;
				case ($urandom_range(7))
					0: d = '0;
					1: d = '1;
					2: d = 32'h8000_0000;
					3: d = 32'h7FFF_FFFF;
					default: d = $urandom;
				endcase
				send_item(act, k, d, 1'b0, no_res);
			end
		end

		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		drain_results();
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
